>>> hw/rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define MSC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// checked at every edge
`define MSC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/msc_pkg.sv
package msc_pkg;

    localparam int W         = 64;
    localparam int W_PROD    = 2 * W;
    localparam int HALF      = W / 2;
    localparam int DIV_STEPS = W_PROD;
    localparam int MOD_STEPS = W;
    localparam int MUL_STAGES = 5;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CURRENT = 2'd0,
        CFG_NEXT    = 2'd1,
        CFG_PLAIN   = 2'd2
    } t_cfg_idx;

    // one restoring step: returns {quotient bit, new remainder}
    function automatic logic [W:0] msc_step(input logic [W-1:0] rem, input logic bit_in,
                                            input logic [W-1:0] den);
        logic [W:0] ext;
        logic [W:0] dif;
        ext = {rem, bit_in};
        dif = ext - {1'b0, den};
        if (ext >= {1'b0, den}) begin
            return {1'b1, dif[W-1:0]};
        end
        return {1'b0, ext[W-1:0]};
    endfunction

    // (a + b) mod m for a, b already below m; zero modulus wraps
    function automatic logic [W-1:0] msc_addmod(input logic [W-1:0] a, input logic [W-1:0] b,
                                                input logic [W-1:0] m);
        logic [W:0] s;
        logic [W:0] d;
        s = {1'b0, a} + {1'b0, b};
        d = s - {1'b0, m};
        if (m != '0 && s >= {1'b0, m}) begin
            return d[W-1:0];
        end
        return s[W-1:0];
    endfunction

    // (m - v) mod m for v already reduced by m
    function automatic logic [W-1:0] msc_negmod(input logic [W-1:0] v, input logic [W-1:0] m);
        if (v == '0) begin
            return '0;
        end
        return m - v;
    endfunction

endpackage

>>> hw/rtl/msc_mul.sv
module msc_mul (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [msc_pkg::W-1:0]      i_a,
    input  logic [msc_pkg::W-1:0]      i_b,
    output logic                       o_valid,
    output logic [msc_pkg::W_PROD-1:0] o_prod,
    output logic [msc_pkg::W-1:0]      o_a
);
    import msc_pkg::*;

    logic [MUL_STAGES-1:0] r_v;
    logic [W-1:0]      r_a1, r_a2, r_a3, r_a4, r_a5;
    logic [W-1:0]      r_m1, r_m2, r_m3, r_m4;
    logic [W_PROD-1:0] r_acc2, r_acc3, r_acc4, r_acc5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[MUL_STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a1   <= i_a;
            r_m1   <= W'(i_a[HALF-1:0] * i_b[HALF-1:0]);
            r_a2   <= r_a1;
            r_m2   <= W'(r_a1[HALF-1:0] * i_b[W-1:HALF]);
            r_acc2 <= {{W{1'b0}}, r_m1};
            r_a3   <= r_a2;
            r_m3   <= W'(r_a2[W-1:HALF] * i_b[HALF-1:0]);
            r_acc3 <= r_acc2 + {{HALF{1'b0}}, r_m2, {HALF{1'b0}}};
            r_a4   <= r_a3;
            r_m4   <= W'(r_a3[W-1:HALF] * i_b[W-1:HALF]);
            r_acc4 <= r_acc3 + {{HALF{1'b0}}, r_m3, {HALF{1'b0}}};
            r_a5   <= r_a4;
            r_acc5 <= r_acc4 + {r_m4, {W{1'b0}}};
        end
    end

    assign o_valid = r_v[MUL_STAGES-1];
    assign o_prod  = r_acc5;
    assign o_a     = r_a5;

endmodule

>>> hw/rtl/msc_div.sv
module msc_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [msc_pkg::W_PROD-1:0] i_prod,
    input  logic [msc_pkg::W-1:0]      i_c,
    input  logic [msc_pkg::W-1:0]      i_den,
    input  logic [msc_pkg::W-1:0]      i_p,
    output logic                       o_valid,
    output logic [msc_pkg::W-1:0]      o_quo,
    output logic [msc_pkg::W-1:0]      o_cp
);
    import msc_pkg::*;

    logic [DIV_STEPS-1:0] r_v;
    logic [W_PROD-1:0]    r_num [DIV_STEPS];
    logic [W-1:0]         r_rem [DIV_STEPS];
    logic [W-1:0]         r_c   [DIV_STEPS];
    logic [W-1:0]         r_cr  [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_st
        logic              w_v;
        logic [W_PROD-1:0] w_num;
        logic [W-1:0]      w_rem;
        logic [W-1:0]      w_c;
        logic [W:0]        w_step;

        if (k == 0) begin : g_first
            assign w_v   = i_valid;
            assign w_num = i_prod;
            assign w_rem = '0;
            assign w_c   = i_c;
        end else begin : g_next
            assign w_v   = r_v[k-1];
            assign w_num = r_num[k-1];
            assign w_rem = r_rem[k-1];
            assign w_c   = r_c[k-1];
        end

        assign w_step = msc_step(w_rem, w_num[W_PROD-1], i_den);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[k] <= {w_num[W_PROD-2:0], w_step[W]};
                r_rem[k] <= w_step[W-1:0];
            end
        end

        // coefficient mod plain modulus over the second half
        if (k < DIV_STEPS - MOD_STEPS) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_c[k] <= w_c;
                end
            end
        end else begin : g_cmod
            logic [W-1:0] w_cr;
            logic [W:0]   w_cstep;
            if (k == DIV_STEPS - MOD_STEPS) begin : g_cr0
                assign w_cr = '0;
            end else begin : g_crn
                assign w_cr = r_cr[k-1];
            end
            assign w_cstep = msc_step(w_cr, w_c[W-1], i_p);
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_c[k]  <= {w_c[W-2:0], 1'b0};
                    r_cr[k] <= w_cstep[W-1:0];
                end
            end
        end
    end

    assign o_valid = r_v[DIV_STEPS-1];
    assign o_quo   = r_num[DIV_STEPS-1][W-1:0];
    assign o_cp    = r_cr[DIV_STEPS-1];

endmodule

>>> hw/rtl/msc_mod.sv
module msc_mod (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [msc_pkg::W-1:0] i_x,
    input  logic [msc_pkg::W-1:0] i_m,
    input  logic [msc_pkg::W-1:0] i_sb,
    output logic                  o_valid,
    output logic [msc_pkg::W-1:0] o_r,
    output logic [msc_pkg::W-1:0] o_sb
);
    import msc_pkg::*;

    logic [MOD_STEPS-1:0] r_v;
    logic [W-1:0]         r_x   [MOD_STEPS];
    logic [W-1:0]         r_rem [MOD_STEPS];
    logic [W-1:0]         r_sb  [MOD_STEPS];

    for (genvar k = 0; k < MOD_STEPS; k++) begin : g_st
        logic         w_v;
        logic [W-1:0] w_x;
        logic [W-1:0] w_rem;
        logic [W-1:0] w_sb;
        logic [W:0]   w_step;

        if (k == 0) begin : g_first
            assign w_v   = i_valid;
            assign w_x   = i_x;
            assign w_rem = '0;
            assign w_sb  = i_sb;
        end else begin : g_next
            assign w_v   = r_v[k-1];
            assign w_x   = r_x[k-1];
            assign w_rem = r_rem[k-1];
            assign w_sb  = r_sb[k-1];
        end

        assign w_step = msc_step(w_rem, w_x[W-1], i_m);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k]   <= {w_x[W-2:0], 1'b0};
                r_rem[k] <= w_step[W-1:0];
                r_sb[k]  <= w_sb;
            end
        end
    end

    assign o_valid = r_v[MOD_STEPS-1];
    assign o_r     = r_rem[MOD_STEPS-1];
    assign o_sb    = r_sb[MOD_STEPS-1];

endmodule

>>> hw/rtl/modulus_switch_coefficient_top.sv
// channel   | valid        | ready        | payload
// request   | i_in_valid   | o_in_ready   | i_coefficient
// result    | o_out_valid  | i_out_ready  | o_switched_coefficient
// config    | i_cfg_we     | (none)       | i_cfg_index, i_cfg_data
//
// one request accepted per cycle while the skid entry is empty
// bulk of the pipeline: the 128-step quotient divider and two 64-step modulo pipelines
// synchronous active-low reset clears valid bits and sets all moduli to 1
// a stalled result waits in the output register, one more in a skid entry;
// the pipeline freezes only when the skid entry is full
module modulus_switch_coefficient_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [msc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [msc_pkg::W-1:0]         i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [msc_pkg::W-1:0]         i_coefficient,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [msc_pkg::W-1:0]         o_switched_coefficient
);
    import msc_pkg::*;
    `include "assert_macros.svh"

    logic [W-1:0] r_cur, r_next, r_plain;
    logic         w_en;

    logic              w_mul_v;
    logic [W_PROD-1:0] w_prod;
    logic [W-1:0]      w_mul_c;
    logic              w_div_v;
    logic [W-1:0]      w_scaled, w_cp;
    logic              w_b_v;
    logic [W-1:0]      w_b, w_b_sb, w_c, w_c_sb;
    logic              w_c_v;
    logic              w_e_v, w_d_v;
    logic [W-1:0]      w_e, w_e_sb, w_d, w_d_sb;

    logic         r_d1_v, r_d2_v, r_f1_v, r_f2_v;
    logic [W-1:0] r_d1_negb, r_d1_cp, r_d1_c;
    logic [W-1:0] r_d2_diff, r_d2_c;
    logic         r_d2_cond;
    logic [W-1:0] r_f1_e, r_f1_negd, r_f1_c;
    logic         r_f1_cond;
    logic [W-1:0] r_f2_f, r_f2_c;
    logic [W-1:0] w_corr, w_res;

    logic         r_out_v, r_skid_v;
    logic [W-1:0] r_out, r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur   <= W'(1);
            r_next  <= W'(1);
            r_plain <= W'(1);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_CURRENT: r_cur   <= i_cfg_data;
                CFG_NEXT:    r_next  <= i_cfg_data;
                CFG_PLAIN:   r_plain <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign w_en       = !r_skid_v;
    assign o_in_ready = w_en;

    msc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in_valid),
        .i_a     (i_coefficient),
        .i_b     (r_next),
        .o_valid (w_mul_v),
        .o_prod  (w_prod),
        .o_a     (w_mul_c)
    );

    msc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_mul_v),
        .i_prod  (w_prod),
        .i_c     (w_mul_c),
        .i_den   (r_cur),
        .i_p     (r_plain),
        .o_valid (w_div_v),
        .o_quo   (w_scaled),
        .o_cp    (w_cp)
    );

    msc_mod u_mod_sp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_div_v),
        .i_x     (w_scaled),
        .i_m     (r_plain),
        .i_sb    (w_cp),
        .o_valid (w_b_v),
        .o_r     (w_b),
        .o_sb    (w_b_sb)
    );

    msc_mod u_mod_sn (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_div_v),
        .i_x     (w_scaled),
        .i_m     (r_next),
        .i_sb    ('0),
        .o_valid (w_c_v),
        .o_r     (w_c),
        .o_sb    (w_c_sb)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1_v <= 1'b0;
            r_d2_v <= 1'b0;
            r_f1_v <= 1'b0;
            r_f2_v <= 1'b0;
        end else if (w_en) begin
            r_d1_v <= w_b_v;
            r_d2_v <= r_d1_v;
            r_f1_v <= w_e_v;
            r_f2_v <= r_f1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d1_negb <= msc_negmod(w_b, r_plain);
            r_d1_cp   <= w_b_sb;
            r_d1_c    <= w_c;
            r_d2_diff <= msc_addmod(r_d1_cp, r_d1_negb, r_plain);
            r_d2_cond <= msc_addmod(r_d1_cp, r_d1_negb, r_plain) <= (r_plain >> 1);
            r_d2_c    <= r_d1_c;
            r_f1_e    <= w_e;
            r_f1_negd <= msc_negmod(w_d, r_next);
            r_f1_c    <= w_e_sb;
            r_f1_cond <= w_d_sb[0];
            r_f2_f    <= w_corr;
            r_f2_c    <= r_f1_c;
        end
    end

    msc_mod u_mod_dn (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_d2_v),
        .i_x     (r_d2_diff),
        .i_m     (r_next),
        .i_sb    (r_d2_c),
        .o_valid (w_e_v),
        .o_r     (w_e),
        .o_sb    (w_e_sb)
    );

    msc_mod u_mod_pn (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_d2_v),
        .i_x     (r_plain),
        .i_m     (r_next),
        .i_sb    ({{(W-1){1'b0}}, r_d2_cond}),
        .o_valid (w_d_v),
        .o_r     (w_d),
        .o_sb    (w_d_sb)
    );

    assign w_corr = r_f1_cond ? r_f1_e : msc_addmod(r_f1_e, r_f1_negd, r_next);
    assign w_res  = msc_addmod(r_f2_c, r_f2_f, r_next);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (i_out_ready) begin
                r_skid_v <= 1'b0;
            end
        end else if (r_f2_v) begin
            if (!r_out_v || i_out_ready) begin
                r_out_v <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end else if (i_out_ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (i_out_ready) begin
                r_out <= r_skid;
            end
        end else if (r_f2_v) begin
            if (!r_out_v || i_out_ready) begin
                r_out <= w_res;
            end else begin
                r_skid <= w_res;
            end
        end
    end

    assign o_out_valid            = r_out_v;
    assign o_switched_coefficient = r_out;

    `MSC_ASSERT(a_skid_needs_out, i_clk, i_rst_n, r_skid_v |-> r_out_v, "skid full while output empty")
    `MSC_ASSERT(a_skid_on_stall, i_clk, i_rst_n, $rose(r_skid_v) |-> $past(r_out_v && !i_out_ready), "skid filled without stall")
    `MSC_ASSERT(a_skid_drain, i_clk, i_rst_n, r_skid_v && i_out_ready |=> r_out == $past(r_skid), "skid entry lost")
    `MSC_ASSERT(a_out_drop, i_clk, i_rst_n, $fell(r_out_v) |-> $past(i_out_ready), "result dropped untaken")

endmodule

>>> verif/modulus_switch_coefficient_top_tb.sv
module modulus_switch_coefficient_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import msc_pkg::*;

    class switch_scoreboard;
        logic [W-1:0] cur_mod;
        logic [W-1:0] next_mod;
        logic [W-1:0] plain_mod;
        logic [W-1:0] pending[$];
        int errors;

        function new();
            cur_mod = 1;
            next_mod = 1;
            plain_mod = 1;
            errors = 0;
        endfunction

        function logic [W-1:0] reduce(logic [W-1:0] x, logic [W-1:0] m);
            return (m == '0) ? x : x % m;
        endfunction

        function logic [W-1:0] sum_mod(logic [W-1:0] a, logic [W-1:0] b, logic [W-1:0] m);
            logic [W:0] s;
            s = {1'b0, a} + {1'b0, b};
            if (m == '0) begin
                return s[W-1:0];
            end
            s = s % {1'b0, m};
            return s[W-1:0];
        endfunction

        function logic [W-1:0] neg_mod(logic [W-1:0] x, logic [W-1:0] m);
            logic [W-1:0] v;
            v = reduce(x, m);
            return (v == '0) ? '0 : m - v;
        endfunction

        function logic [W-1:0] switch_coefficient(logic [W-1:0] c);
            logic [W_PROD-1:0] prod;
            logic [W_PROD-1:0] quo;
            logic [W-1:0] scaled;
            logic [W-1:0] diff;
            logic [W-1:0] corr;
            prod = {{W{1'b0}}, c} * {{W{1'b0}}, next_mod};
            if (cur_mod == '0) begin
                scaled = '1;
            end else begin
                quo = prod / {{W{1'b0}}, cur_mod};
                scaled = quo[W-1:0];
            end
            diff = sum_mod(reduce(c, plain_mod), neg_mod(reduce(scaled, plain_mod), plain_mod),
                           plain_mod);
            if (diff <= (plain_mod >> 1)) begin
                corr = diff;
            end else begin
                corr = sum_mod(reduce(diff, next_mod), neg_mod(plain_mod, next_mod), next_mod);
            end
            return sum_mod(reduce(scaled, next_mod), reduce(corr, next_mod), next_mod);
        endfunction

        function void note_request(logic [W-1:0] c);
            pending.push_back(switch_coefficient(c));
        endfunction

        function void check_result(logic [W-1:0] got);
            logic [W-1:0] want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                $display("%0t: switched_coefficient expected %h, actual %h", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic          i_clk;
    logic          i_rst_n;
    logic          i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [W-1:0]  i_cfg_data;
    logic          i_in_valid;
    logic          o_in_ready;
    logic [W-1:0]  i_coefficient;
    logic          o_out_valid;
    logic          i_out_ready;
    logic [W-1:0]  o_switched_coefficient;

    switch_scoreboard sb = new();
    int sent_count = 0;
    bit no_gap_mode = 0;

    modulus_switch_coefficient_top u_top (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg_we               (i_cfg_we),
        .i_cfg_index            (i_cfg_index),
        .i_cfg_data             (i_cfg_data),
        .i_in_valid             (i_in_valid),
        .o_in_ready             (o_in_ready),
        .i_coefficient          (i_coefficient),
        .o_out_valid            (o_out_valid),
        .i_out_ready            (i_out_ready),
        .o_switched_coefficient (o_switched_coefficient)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic logic [W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send_request(logic [W-1:0] c);
        int gap;
        gap = no_gap_mode ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_coefficient <= c;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(c);
        sent_count++;
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [W-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_CURRENT: sb.cur_mod = value;
            CFG_NEXT:    sb.next_mod = value;
            default:     sb.plain_mod = value;
        endcase
    endtask

    task automatic set_moduli(logic [W-1:0] cur, logic [W-1:0] nxt, logic [W-1:0] pl);
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        write_reg(CFG_CURRENT, cur);
        write_reg(CFG_NEXT, nxt);
        write_reg(CFG_PLAIN, pl);
    endtask

    task automatic run_random(int count);
        logic [W-1:0] c;
        for (int i = 0; i < count; i++) begin
            no_gap_mode = ((i / 40) % 3 == 2);
            case ($urandom_range(0, 19))
                0:       c = '0;
                1:       c = sb.cur_mod - 1;
                2:       c = '1;
                3, 4:    c = rand64();
                default: c = (sb.cur_mod == '0) ? rand64() : rand64() % sb.cur_mod;
            endcase
            send_request(c);
        end
        no_gap_mode = 0;
    endtask

    // receiver: random stalls, one long hold-off to back up the pipeline
    initial begin
        int stall;
        int got;
        got = 0;
        i_out_ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (got == 60) begin
                i_out_ready <= 1'b0;
                repeat (3000) @(posedge i_clk);
            end else begin
                stall = ((got / 50) % 4 == 3) ? 0 : $urandom_range(0, 15);
                if (stall > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            sb.check_result(o_switched_coefficient);
            got++;
        end
    end

    initial begin
        logic [W-1:0] a;
        logic [W-1:0] b;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= CFG_CURRENT;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_coefficient <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset moduli, then extremes
        send_request('0);
        send_request('1);
        send_request(64'h5555_5555_5555_5555);
        set_moduli('1, '1 - 1, '1 - 2);
        send_request('0);
        send_request(1);
        send_request('1 - 1);
        send_request('1);
        send_request(64'h8000_0000_0000_0000);
        set_moduli(64'd1000003, 64'd65537, 64'd257);
        send_request(64'd1000002);
        send_request(64'd1000003);
        send_request(64'd128);
        send_request(64'd129);
        set_moduli('0, 64'd97, 64'd7);
        send_request(64'd12345);
        send_request('1);
        set_moduli(64'd1000, '0, 64'd10);
        send_request(64'd999);
        send_request(64'd500);
        set_moduli(64'd1000, 64'd100, '0);
        send_request(64'd999);
        send_request(64'd333);
        set_moduli(64'd1000, 64'd100, 64'd250);
        send_request(64'd777);
        send_request(64'd1);

        set_moduli(64'd1000003, 64'd65537, 64'd257);
        run_random(400);
        set_moduli('1, 64'hFFFF_FFFF_0000_0001, 64'h0000_0000_0001_0001);
        run_random(150);
        for (int k = 0; k < 5; k++) begin
            a = rand64() | 64'h8000_0000_0000_0000;
            b = rand64() % a;
            set_moduli(a, b, (b == '0) ? 64'd2 : rand64() % b);
            run_random(90);
        end
        set_moduli(rand64(), rand64(), rand64());
        run_random(100);
        set_moduli('0, '0, '0);
        run_random(50);

        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("modulus_switch_coefficient_top: match");
        end else begin
            $display("modulus_switch_coefficient_top: mismatch");
        end
        $finish;
    end

    initial begin
        #8ms;
        $display("modulus_switch_coefficient_top: mismatch");
        $finish;
    end

endmodule
